>>> rtl/itp_pkg.sv
// shared types, operator codes and decode functions for the infix to postfix converter
package itp_pkg;

  // operator codes kept on the stack
  typedef logic [2:0] code_t;

  localparam code_t CODE_OPEN = 3'd0;
  localparam code_t CODE_ADD  = 3'd1;
  localparam code_t CODE_SUB  = 3'd2;
  localparam code_t CODE_MUL  = 3'd3;
  localparam code_t CODE_DIV  = 3'd4;
  localparam code_t CODE_NONE = 3'd7;

  // ascii bytes with a meaning of their own
  localparam logic [7:0] CHAR_OPEN  = 8'h28;
  localparam logic [7:0] CHAR_CLOSE = 8'h29;
  localparam logic [7:0] CHAR_ADD   = 8'h2b;
  localparam logic [7:0] CHAR_SUB   = 8'h2d;
  localparam logic [7:0] CHAR_MUL   = 8'h2a;
  localparam logic [7:0] CHAR_DIV   = 8'h2f;

  // input item
  typedef struct packed {
    logic [7:0] symbol;
    logic       is_last;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [7:0] out_symbol;
    logic       symbol_valid;
    logic       run_last;
    logic       expression_end;
    logic       overflow_error;
    logic       paren_error;
  } out_item_t;

  // arithmetic operator byte to code, anything else gives the none code
  function automatic code_t op_code(input logic [7:0] sym);
    code_t c;
    case (sym)
      CHAR_ADD: c = CODE_ADD;
      CHAR_SUB: c = CODE_SUB;
      CHAR_MUL: c = CODE_MUL;
      CHAR_DIV: c = CODE_DIV;
      default:  c = CODE_NONE;
    endcase
    return c;
  endfunction

  // binding strength, open parenthesis lowest
  function automatic logic [1:0] op_priority(input code_t c);
    logic [1:0] p;
    case (c)
      CODE_ADD, CODE_SUB: p = 2'd1;
      CODE_MUL, CODE_DIV: p = 2'd2;
      default:            p = 2'd0;
    endcase
    return p;
  endfunction

  // stack code back to its ascii byte
  function automatic logic [7:0] code_to_byte(input code_t c);
    logic [7:0] b;
    case (c)
      CODE_OPEN: b = CHAR_OPEN;
      CODE_ADD:  b = CHAR_ADD;
      CODE_SUB:  b = CHAR_SUB;
      CODE_MUL:  b = CHAR_MUL;
      CODE_DIV:  b = CHAR_DIV;
      default:   b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

>>> rtl/itp_stack_ram.sv
// operator stack storage: one write port, one registered read port
module itp_stack_ram #(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  itp_pkg::code_t           wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output itp_pkg::code_t           rd_data
);
  import itp_pkg::*;

  code_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/infix_to_postfix_converter.sv
// infix to postfix converter top level: item sequencer around the operator stack memory
//
//   channel | ports                            | accepted when
//   --------+----------------------------------+--------------------------
//   input   | in_valid, in_stall, in_data      | in_valid && !in_stall
//   output  | out_valid, out_stall, out_data   | out_valid && !out_stall
//
// one item at a time: the sequencer accepts it, pops operators one by one, makes a decision
// (push, pass the operand, pop the matching open parenthesis or find the stack empty)
// and closes. the last item adds a flush that pops every entry left before the close.
// pops follow the stack read, one entry per cycle unless an output stall holds them.
// rst is synchronous; it empties the stack and clears the error flags and the output.
// a stall on the output holds the sequencer only when a result has nowhere to go:
// one result waits in a hold register so the last result of an item can be marked.
module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  itp_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output itp_pkg::out_item_t  out_data
);
  import itp_pkg::*;

  localparam int IDX_W = $clog2(STACK_DEPTH);
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(STACK_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_OPERAND,
    S_OPER,
    S_CLOSE,
    S_FLUSH,
    S_END
  } state_t;

  state_t           state, state_next;
  logic [7:0]       cur_symbol;
  code_t            cur_code;
  logic             cur_last;
  logic [CNT_W-1:0] count;
  code_t            top_reg;
  logic             top_from_mem;
  logic             overflow_seen;
  logic             paren_fault_seen;
  logic             hold_valid;
  out_item_t        hold;

  code_t            rd_data;
  code_t            top;
  logic             out_free;
  logic             can_emit;
  logic             stack_empty;
  logic             stack_full;
  logic             accept;
  state_t           after_run;

  logic             emit_en;
  logic [7:0]       emit_byte;
  logic             pop_en;
  logic             push_en;
  logic             set_ovf;
  logic             set_paren;
  logic             final_en;
  logic             out_load;
  out_item_t        out_load_data;
  logic             rd_en;

  assign in_stall    = (state != S_IDLE);
  assign accept      = in_valid && !in_stall;
  assign top         = top_from_mem ? rd_data : top_reg;
  assign out_free    = !out_valid || !out_stall;
  assign can_emit    = !hold_valid || out_free;
  assign stack_empty = (count == '0);
  assign stack_full  = (count == FULL_COUNT);
  assign after_run   = cur_last ? S_FLUSH : S_END;

  // stack memory
  assign rd_en = pop_en && (count > CNT_W'(1));

  itp_stack_ram #(
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (push_en),
    .wr_addr (count[IDX_W-1:0]),
    .wr_data (cur_code),
    .rd_en   (rd_en),
    .rd_addr (IDX_W'(count - CNT_W'(2))),
    .rd_data (rd_data)
  );

  // sequencer decisions
  always_comb begin
    state_next = state;
    emit_en    = 1'b0;
    emit_byte  = '0;
    pop_en     = 1'b0;
    push_en    = 1'b0;
    set_ovf    = 1'b0;
    set_paren  = 1'b0;
    final_en   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.symbol == CHAR_OPEN || op_code(in_data.symbol) != CODE_NONE) begin
            state_next = S_OPER;
          end else if (in_data.symbol == CHAR_CLOSE) begin
            state_next = S_CLOSE;
          end else begin
            state_next = S_OPERAND;
          end
        end
      end
      S_OPERAND: begin
        if (can_emit) begin
          emit_en    = 1'b1;
          emit_byte  = cur_symbol;
          state_next = after_run;
        end
      end
      S_OPER: begin
        if (!stack_empty && cur_code != CODE_OPEN &&
            op_priority(cur_code) <= op_priority(top)) begin
          if (can_emit) begin
            emit_en   = 1'b1;
            emit_byte = code_to_byte(top);
            pop_en    = 1'b1;
          end
        end else begin
          if (stack_full) begin
            set_ovf = 1'b1;
          end else begin
            push_en = 1'b1;
          end
          state_next = after_run;
        end
      end
      S_CLOSE: begin
        if (stack_empty) begin
          set_paren  = 1'b1;
          state_next = after_run;
        end else if (top != CODE_OPEN) begin
          if (can_emit) begin
            emit_en   = 1'b1;
            emit_byte = code_to_byte(top);
            pop_en    = 1'b1;
          end
        end else begin
          pop_en     = 1'b1;
          state_next = after_run;
        end
      end
      S_FLUSH: begin
        if (stack_empty) begin
          state_next = S_END;
        end else if (top != CODE_OPEN) begin
          if (can_emit) begin
            emit_en   = 1'b1;
            emit_byte = code_to_byte(top);
            pop_en    = 1'b1;
          end
        end else begin
          pop_en = 1'b1;
        end
      end
      S_END: begin
        if (hold_valid || cur_last) begin
          if (out_free) begin
            final_en   = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // what goes into the output register
  always_comb begin
    out_load      = (emit_en && hold_valid) || final_en;
    out_load_data = hold;
    if (final_en) begin
      if (hold_valid) begin
        out_load_data.run_last       = 1'b1;
        out_load_data.expression_end = cur_last;
      end else begin
        out_load_data.out_symbol     = '0;
        out_load_data.symbol_valid   = 1'b0;
        out_load_data.run_last       = 1'b1;
        out_load_data.expression_end = 1'b1;
        out_load_data.overflow_error = overflow_seen;
        out_load_data.paren_error    = paren_fault_seen;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      count            <= '0;
      top_from_mem     <= 1'b0;
      overflow_seen    <= 1'b0;
      paren_fault_seen <= 1'b0;
      hold_valid       <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_load || (out_valid && out_stall);
      if (pop_en) begin
        count        <= count - CNT_W'(1);
        top_from_mem <= 1'b1;
      end else if (push_en) begin
        count        <= count + CNT_W'(1);
        top_from_mem <= 1'b0;
      end
      if (final_en && cur_last) begin
        overflow_seen    <= 1'b0;
        paren_fault_seen <= 1'b0;
      end else begin
        if (set_ovf) begin
          overflow_seen <= 1'b1;
        end
        if (set_paren) begin
          paren_fault_seen <= 1'b1;
        end
      end
      if (emit_en) begin
        hold_valid <= 1'b1;
      end else if (final_en) begin
        hold_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_symbol <= in_data.symbol;
      cur_last   <= in_data.is_last;
      cur_code   <= (in_data.symbol == CHAR_OPEN) ? CODE_OPEN : op_code(in_data.symbol);
    end
    if (push_en) begin
      top_reg <= cur_code;
    end
    if (emit_en) begin
      hold.out_symbol     <= emit_byte;
      hold.symbol_valid   <= 1'b1;
      hold.run_last       <= 1'b0;
      hold.expression_end <= 1'b0;
      hold.overflow_error <= overflow_seen;
      hold.paren_error    <= paren_fault_seen;
    end
    if (out_load) begin
      out_data <= out_load_data;
    end
  end

endmodule
